### design/two_level_write_back_cache_defines.svh
// ----------------------------------------------------------------------------
// two_level_write_back_cache_defines
// Assertion macros for the two-level cache.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_WRITE_BACK_CACHE_DEFINES_SVH
`define TWO_LEVEL_WRITE_BACK_CACHE_DEFINES_SVH
// assert that a condition implies a consequence in the same cycle
`define TLC_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// assert that a condition implies a consequence in the next cycle
`define TLC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### design/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared constants and types of the two-level write-back cache.
// ----------------------------------------------------------------------------
`default_nettype none
package tlc_pkg;
  localparam int WORD_BYTES  = 4;
  localparam int BLOCK_BYTES = 16;
  localparam int NEAR_LINES  = 16;
  localparam int FAR_LINES   = 32;
  localparam int STORE_BYTES = 65536;
  localparam int ADDR_W = 16;
  localparam int COST_W = 10;
  localparam int TOTAL_W = 32;
  localparam int NUM_REGS = 6;
  localparam logic [2:0] REG_L1_RD  = 3'd0;
  localparam logic [2:0] REG_L1_WR  = 3'd1;
  localparam logic [2:0] REG_L2_RD  = 3'd2;
  localparam logic [2:0] REG_L2_WR  = 3'd3;
  localparam logic [2:0] REG_MEM_RD = 3'd4;
  localparam logic [2:0] REG_MEM_WR = 3'd5;
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;
endpackage
`default_nettype wire

### design/two_level_write_back_cache.sv
// ----------------------------------------------------------------------------
// two_level_write_back_cache
// Two-level direct-mapped write-back cache. A sequencer runs each word through
// L1, L2 and the backing store, moving one block per step through one shared
// block path and adding costs with one adder. An L1 hit passes through the
// lookup, word, settle and output states, and the next word is taken once
// the sequencer is back in idle. Each L2 block access on an L1 miss (victim
// write-back or fill) goes through the L2 lookup and done states, an L2 miss
// adds a store read and a dirty L2 victim a store write. A stalled result
// holds the sequencer before it can present the next one. After reset the
// store is cleared while in_stall stays high.
// ----------------------------------------------------------------------------
`default_nettype none
module two_level_write_back_cache #(
  parameter int BLOCK_BYTES = tlc_pkg::BLOCK_BYTES,
  parameter int NEAR_LINES  = tlc_pkg::NEAR_LINES,
  parameter int FAR_LINES   = tlc_pkg::FAR_LINES,
  parameter int STORE_BYTES = tlc_pkg::STORE_BYTES
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [tlc_pkg::COST_W-1:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic op,
  input  wire logic [tlc_pkg::ADDR_W-1:0] address,
  input  wire logic [31:0] write_data,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [31:0] read_data,
  output logic l1_hit,
  output logic l2_hit,
  output logic bad_address,
  output logic [31:0] elapsed_cycles
);
  localparam int BB = BLOCK_BYTES * 8;
  localparam int OFFW = $clog2(BLOCK_BYTES);
  localparam int SBLK = (STORE_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam int SAW = $clog2(SBLK);
  localparam int NW = $clog2(NEAR_LINES);
  localparam int FW = $clog2(FAR_LINES);
  localparam int BAW = 20 - OFFW; // block number width for up to 1 MiB
  localparam int EXTRA = (STORE_BYTES % BLOCK_BYTES == 0) ? 0 :
                         (STORE_BYTES % BLOCK_BYTES);

  localparam logic [3:0] S_IDLE = 4'd0, S_LOOK = 4'd1, S_NWB = 4'd2, S_NWB2 = 4'd3,
    S_FILL = 4'd4, S_FILL2 = 4'd5, S_FAR = 4'd6, S_FWB = 4'd7, S_SRD = 4'd8,
    S_SRD2 = 4'd9, S_FDONE = 4'd10, S_WORD = 4'd11, S_OUT = 4'd12;
  logic [3:0] state;

  logic [tlc_pkg::COST_W-1:0] costs [tlc_pkg::NUM_REGS];
  logic [NEAR_LINES-1:0] nv, nd;
  logic [FAR_LINES-1:0] fv, fd;
  logic [BAW-1:0] ntag [NEAR_LINES];
  logic [BAW-1:0] ftag [FAR_LINES];
  logic [BB-1:0] nblk [NEAR_LINES];
  logic [BB-1:0] fblk [FAR_LINES];

  logic opr;
  logic [BAW-1:0] blk_no;
  logic [OFFW-1:0] off;
  logic [31:0] wd;
  logic [31:0] total;
  logic [BB-1:0] buffer;     // block in flight
  logic [BAW-1:0] far_blk;   // block number addressed at L2
  logic far_wr, fhit, l2h;
  logic l1h, bad;
  logic [31:0] rword;
  logic [FW-1:0] fi;
  logic [NW-1:0] ni;
  logic [tlc_pkg::COST_W-1:0] add, add_next;

  logic st_we, st_busy;
  logic [SAW-1:0] st_wa, st_ra;
  logic [BB-1:0] st_wd, st_rd;

  tlc_store #(.BLOCK_BITS(BB), .DEPTH(1 << SAW)) u_store (
    .clk(clk), .rst(rst), .we(st_we), .waddr(st_wa), .wdata(st_wd),
    .raddr(st_ra), .rdata(st_rd), .busy(st_busy)
  );

  assign ni = blk_no[NW-1:0];
  assign fi = far_blk[FW-1:0];
  assign in_stall = (state != S_IDLE) || st_busy;

  // mask store bytes past the end on a partial last block
  function automatic logic [BB-1:0] tail_mask(input logic [BAW-1:0] b);
    logic [BB-1:0] m;
    m = '1;
    if (EXTRA != 0 && 32'(b) == SBLK - 1) begin
      m = '0;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        if (i < EXTRA) m[i*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

  logic [BAW-1:0] victim_blk;
  always_comb begin
    victim_blk = ftag[fi];
    st_we = (state == S_FWB) && (32'(victim_blk) < SBLK);
    st_wa = victim_blk[SAW-1:0];
    st_wd = fblk[fi] & tail_mask(victim_blk);
    st_ra = far_blk[SAW-1:0];
  end

  // cost charged by the current step, registered in add and then summed into total
  always_comb begin
    case (state)
      S_FWB: add_next = costs[tlc_pkg::REG_MEM_WR];
      S_SRD2: add_next = costs[tlc_pkg::REG_MEM_RD];
      S_FDONE: add_next = far_wr ? costs[tlc_pkg::REG_L2_WR] : costs[tlc_pkg::REG_L2_RD];
      S_WORD: add_next = (opr == tlc_pkg::OP_WRITE) ? costs[tlc_pkg::REG_L1_WR] :
                                                      costs[tlc_pkg::REG_L1_RD];
      default: add_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      nv <= '0; nd <= '0; fv <= '0; fd <= '0;
      total <= '0;
      costs[tlc_pkg::REG_L1_RD] <= 10'd1;  costs[tlc_pkg::REG_L1_WR] <= 10'd1;
      costs[tlc_pkg::REG_L2_RD] <= 10'd10; costs[tlc_pkg::REG_L2_WR] <= 10'd10;
      costs[tlc_pkg::REG_MEM_RD] <= 10'd100; costs[tlc_pkg::REG_MEM_WR] <= 10'd100;
      add <= '0;
    end else begin
      if (cfg_we && cfg_index < 3'(tlc_pkg::NUM_REGS)) costs[cfg_index] <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      total <= total + 32'(add);
      add <= add_next;
      case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          opr <= op;
          blk_no <= BAW'({4'd0, address} >> OFFW);
          off <= address[OFFW-1:0] & ~OFFW'(3);
          wd <= write_data;
          if (32'({address[15:2], 2'b00}) >= STORE_BYTES) begin
            bad <= 1'b1; rword <= '0; l1h <= 1'b0; l2h <= 1'b0;
            state <= S_OUT;
          end else begin
            bad <= 1'b0;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          l2h <= 1'b0;
          if (nv[ni] && ntag[ni] == blk_no) begin
            l1h <= 1'b1; state <= S_WORD;
          end else begin
            l1h <= 1'b0;
            state <= nd[ni] ? S_NWB : S_FILL;
          end
        end
        S_NWB: begin
          buffer <= nblk[ni]; far_blk <= ntag[ni]; far_wr <= 1'b1;
          nd[ni] <= 1'b0; state <= S_FAR;
        end
        S_FILL: begin
          far_blk <= blk_no; far_wr <= 1'b0; state <= S_FAR;
        end
        S_FAR: begin
          fhit <= fv[fi] && ftag[fi] == far_blk;
          if (fv[fi] && ftag[fi] == far_blk) state <= S_FDONE;
          else if (fd[fi]) state <= S_FWB;
          else state <= S_SRD;
        end
        S_FWB: begin
          fd[fi] <= 1'b0; state <= S_SRD;
        end
        S_SRD: state <= S_SRD2; // store read in flight
        S_SRD2: begin
          fblk[fi] <= (32'(far_blk) < SBLK) ? (st_rd & tail_mask(far_blk)) : '0;
          fv[fi] <= 1'b1; ftag[fi] <= far_blk;
          state <= S_FDONE;
        end
        S_FDONE: begin
          if (far_wr) begin
            fblk[fi] <= buffer; fd[fi] <= 1'b1;
            state <= S_FILL;
          end else begin
            nblk[ni] <= fblk[fi]; nv[ni] <= 1'b1; ntag[ni] <= blk_no;
            l2h <= fhit; state <= S_WORD;
          end
        end
        S_WORD: begin
          if (opr == tlc_pkg::OP_WRITE) begin
            nblk[ni][{off[OFFW-1:2], 2'b00, 3'b000} +: 32] <= wd;
            nd[ni] <= 1'b1; rword <= '0;
          end else begin
            rword <= nblk[ni][{off[OFFW-1:2], 2'b00, 3'b000} +: 32];
          end
          state <= S_NWB2;
        end
        S_NWB2: state <= S_OUT; // let the last cost land
        S_OUT: if (!out_valid) begin
          read_data <= rword;
          l1_hit <= l1h;
          l2_hit <= l2h;
          bad_address <= bad;
          elapsed_cycles <= total;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "two_level_write_back_cache_defines.svh"
  `TLC_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, in_stall)
  `TLC_ASSERT_NEXT(a_out_once, clk, rst, state == S_OUT && !out_valid, out_valid)
  `TLC_ASSERT_IMP(a_bad_nohit, clk, rst, out_valid && bad_address, !l1_hit && !l2_hit)
endmodule
`default_nettype wire

### design/tlc_store.sv
// ----------------------------------------------------------------------------
// tlc_store
// Backing store block memory with a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module tlc_store #(
  parameter int BLOCK_BITS = 128,
  parameter int DEPTH = 4096
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [BLOCK_BITS-1:0] wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [BLOCK_BITS-1:0] rdata,
  output logic busy
);
  localparam int AW = $clog2(DEPTH);
  logic [BLOCK_BITS-1:0] mem [DEPTH];
  logic [AW:0] clr;
  assign busy = !clr[AW];
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (busy) begin
      clr <= clr + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr[AW-1:0]] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sim/tb_two_level_write_back_cache.sv
// ----------------------------------------------------------------------------
// tb_two_level_write_back_cache
// Self-checking bench for the two-level write-back cache: a behavioral copy of
// both cache levels and the backing store predicts every word result, while
// directed and random accesses run under default, zero, maximum and random cost settings and stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_two_level_write_back_cache;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit [31:0] rdata;
    bit        hit1;
    bit        hit2;
    bit        bad;
    bit [31:0] total;
  } access_result_t;

  typedef logic [tlc_pkg::COST_W-1:0] cost_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = tlc_pkg::REG_L1_RD;
  logic [tlc_pkg::COST_W-1:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = tlc_pkg::OP_READ;
  logic [tlc_pkg::ADDR_W-1:0] address = '0;
  logic [31:0] write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_data;
  logic        l1_hit;
  logic        l2_hit;
  logic        bad_address;
  logic [31:0] elapsed_cycles;

  two_level_write_back_cache uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .address(address), .write_data(write_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .l1_hit(l1_hit), .l2_hit(l2_hit),
    .bad_address(bad_address), .elapsed_cycles(elapsed_cycles)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the cache hierarchy
  bit [tlc_pkg::COST_W-1:0] cost [tlc_pkg::NUM_REGS];
  bit          l1_valid [tlc_pkg::NEAR_LINES];
  bit          l1_dirty [tlc_pkg::NEAR_LINES];
  bit [7:0]    l1_tag   [tlc_pkg::NEAR_LINES];
  bit [127:0]  l1_blk   [tlc_pkg::NEAR_LINES];
  bit          l2_valid [tlc_pkg::FAR_LINES];
  bit          l2_dirty [tlc_pkg::FAR_LINES];
  bit [6:0]    l2_tag   [tlc_pkg::FAR_LINES];
  bit [127:0]  l2_blk   [tlc_pkg::FAR_LINES];
  bit [127:0]  mem_blk  [tlc_pkg::STORE_BYTES/tlc_pkg::BLOCK_BYTES];
  bit [31:0]   cycle_sum;

  access_result_t pending_words[$];
  int  errors = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  l1_hits_seen = 0;
  int  l2_hits_seen = 0;
  bit  idle_on = 1'b0;
  int  stall_left = 0;
  int  cycle_count = 0;

  // whole-block access to L2; returns the hit flag
  function automatic bit l2_block_move(bit [15:0] base, ref bit [127:0] blk, input bit wr);
    bit [4:0] fi;
    bit [6:0] ft;
    bit hit;
    fi = base[8:4];
    ft = base[15:9];
    hit = l2_valid[fi] && l2_tag[fi] == ft;
    if (!hit) begin
      if (l2_dirty[fi]) begin
        mem_blk[{l2_tag[fi], fi}] = l2_blk[fi];
        cycle_sum += cost[tlc_pkg::REG_MEM_WR];
        l2_dirty[fi] = 1'b0;
      end
      l2_blk[fi] = mem_blk[base[15:4]];
      cycle_sum += cost[tlc_pkg::REG_MEM_RD];
      l2_valid[fi] = 1'b1;
      l2_tag[fi] = ft;
    end
    if (wr) begin
      l2_blk[fi] = blk;
      l2_dirty[fi] = 1'b1;
      cycle_sum += cost[tlc_pkg::REG_L2_WR];
    end else begin
      blk = l2_blk[fi];
      cycle_sum += cost[tlc_pkg::REG_L2_RD];
    end
    return hit;
  endfunction

  function automatic access_result_t predict_access(bit wr, bit [15:0] a, bit [31:0] wd);
    access_result_t r;
    bit [15:0] aa;
    bit [3:0] ni;
    bit [7:0] nt;
    bit [127:0] blk;
    bit dummy;
    aa = {a[15:2], 2'b00};
    r = '{default: 0};
    if ({16'd0, aa} >= tlc_pkg::STORE_BYTES) begin
      r.bad = 1'b1;
      r.total = cycle_sum;
      return r;
    end
    ni = aa[7:4];
    nt = aa[15:8];
    r.hit1 = l1_valid[ni] && l1_tag[ni] == nt;
    if (!r.hit1) begin
      if (l1_dirty[ni]) begin
        blk = l1_blk[ni];
        dummy = l2_block_move({l1_tag[ni], ni, 4'b0}, blk, 1'b1);
        l1_dirty[ni] = 1'b0;
      end
      blk = l1_blk[ni];
      r.hit2 = l2_block_move({aa[15:4], 4'b0}, blk, 1'b0);
      l1_blk[ni] = blk;
      l1_valid[ni] = 1'b1;
      l1_tag[ni] = nt;
    end
    if (wr) begin
      l1_blk[ni][aa[3:2]*32 +: 32] = wd;
      l1_dirty[ni] = 1'b1;
      cycle_sum += cost[tlc_pkg::REG_L1_WR];
    end else begin
      r.rdata = l1_blk[ni][aa[3:2]*32 +: 32];
      cycle_sum += cost[tlc_pkg::REG_L1_RD];
    end
    r.total = cycle_sum;
    return r;
  endfunction

  // drive one word, return at the edge that takes it
  task automatic send_access(bit wr, bit [15:0] a, bit [31:0] wd);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= wr ? tlc_pkg::OP_WRITE : tlc_pkg::OP_READ;
    address <= a;
    write_data <= wd;
    pending_words.push_back(predict_access(wr, a, wd));
    words_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // write all six costs on consecutive edges, block idle
  task automatic set_costs(cost_t c0, cost_t c1, cost_t c2,
                           cost_t c3, cost_t c4, cost_t c5);
    bit [tlc_pkg::COST_W-1:0] v [tlc_pkg::NUM_REGS];
    drain_words();
    v = '{c0, c1, c2, c3, c4, c5};
    for (int i = 0; i < tlc_pkg::NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= v[i];
      @(posedge clk);
      cost[i] = v[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic bit [15:0] pick_address(bit [7:0] hot [4]);
    bit [15:0] a;
    a = 16'($urandom);
    // keep most traffic on a few tags so both levels hit and evict
    if ($urandom_range(0, 9) < 8) a[15:8] = hot[$urandom_range(0, 3)];
    return a;
  endfunction

  task automatic test_directed();
    send_access(1'b0, 16'h0000, 32'h0);
    send_access(1'b1, 16'h0000, 32'hFFFF_FFFF);
    send_access(1'b0, 16'h0003, 32'h0);          // low bits ignored
    send_access(1'b1, 16'hFFFC, 32'hA5A5_5A5A);  // top of store, write on miss
    send_access(1'b0, 16'hFFFF, 32'h0);
    send_access(1'b1, 16'h0004, 32'h1234_5678);
    send_access(1'b1, 16'h0008, 32'h0);
    send_access(1'b1, 16'h000C, 32'hDEAD_BEEF);
    // same L1 line, other tag: dirty L1 victim goes to L2
    send_access(1'b0, 16'h0100, 32'h0);
    send_access(1'b0, 16'h000C, 32'h0);
    // same L2 line too: dirty L2 victim goes to the store
    send_access(1'b1, 16'h0200, 32'h0BAD_F00D);
    send_access(1'b1, 16'h0400, 32'h7777_0000);
    send_access(1'b0, 16'h0000, 32'h0);
    send_access(1'b0, 16'h0200, 32'h0);
    send_access(1'b0, 16'h0404, 32'h0);
    send_access(1'b1, 16'h8000, 32'h8000_0001);
    send_access(1'b0, 16'h8000, 32'h0);
    send_access(1'b0, 16'h0004, 32'h0);
  endtask

  task automatic test_cost_extremes();
    set_costs('0, '0, '0, '0, '0, '0);
    send_access(1'b0, 16'h0000, 32'h0);
    send_access(1'b1, 16'h1000, 32'h5555_AAAA);
    send_access(1'b0, 16'h3000, 32'h0);
    set_costs('1, '1, '1, '1, '1, '1);
    send_access(1'b0, 16'h1000, 32'h0);
    send_access(1'b1, 16'h0000, 32'hAAAA_5555);
    send_access(1'b0, 16'h5000, 32'h0);
    send_access(1'b0, 16'h0000, 32'h0);
  endtask

  task automatic test_random_phase(int count, bit idle);
    bit [7:0] hot [4];
    idle_on = idle;
    for (int i = 0; i < 4; i++) hot[i] = 8'($urandom);
    for (int n = 0; n < count; n++) begin
      send_access(1'($urandom_range(0, 1)), pick_address(hot), $urandom);
      if (n == count / 2 && idle) begin
        // hold until every word is back, then resume
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
      end
    end
  endtask

  task automatic test_random_costs();
    for (int p = 0; p < 5; p++) begin
      set_costs(cost_t'($urandom), cost_t'($urandom), cost_t'($urandom),
                cost_t'($urandom), cost_t'($urandom), cost_t'($urandom));
      test_random_phase(130, 1'b1);
    end
    set_costs(10'd1, 10'd1, 10'd10, 10'd10, 10'd100, 10'd100);
    test_random_phase(100, 1'b0);
  endtask

  // result stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    access_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = pending_words.pop_front();
        words_checked++;
        if (e.hit1) l1_hits_seen++;
        if (e.hit2) l2_hits_seen++;
        if (read_data !== e.rdata) begin
          $error("read_data exp %h got %h", e.rdata, read_data); errors++;
        end
        if (l1_hit !== e.hit1) begin
          $error("l1_hit exp %0d got %0d", e.hit1, l1_hit); errors++;
        end
        if (l2_hit !== e.hit2) begin
          $error("l2_hit exp %0d got %0d", e.hit2, l2_hit); errors++;
        end
        if (bad_address !== e.bad) begin
          $error("bad_address exp %0d got %0d", e.bad, bad_address); errors++;
        end
        if (elapsed_cycles !== e.total) begin
          $error("elapsed_cycles exp %0d got %0d", e.total, elapsed_cycles); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    cost = '{1, 1, 10, 10, 100, 100};
    cycle_sum = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // wait out the store clearing pass
    @(posedge clk);
    while (in_stall) @(posedge clk);
    idle_on = 1'b1;
    test_directed();
    test_cost_extremes();
    test_random_costs();
    drain_words();
    $display("Ran %0d words (%0d checked, %0d L1 hits, %0d L2 fills that hit)",
             words_sent, words_checked, l1_hits_seen, l2_hits_seen);
    $display("over default, zero, maximum and random cost settings");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
